// ----- design/bfmtf_pkg.sv -----
// ----------------------------------------------------------------------------
// bfmtf_pkg
// Shared types and constants for the byte frequency move-to-front list.
// ----------------------------------------------------------------------------
package bfmtf_pkg;

	localparam int LIST_DEPTH      = 256;
	localparam int ADDR_W          = $clog2(LIST_DEPTH);
	localparam int LEN_W           = ADDR_W + 1;
	localparam int BYTE_W          = 8;
	localparam int OUT_COUNT_W     = 32;
	localparam int DEF_COUNT_WIDTH = 32;

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} bfmtf_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_HEAD,
		ST_READ,
		ST_LOAD
	} bfmtf_state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic hit;
		logic shift;
		logic head;
		logic append;
		logic rd_issue;
		logic load;
	} bfmtf_cmd_t;

	typedef struct packed {
		logic match;
		logic miss;
		logic shift_done;
		logic out_busy;
	} bfmtf_sts_t;

endpackage

// ----- design/bfmtf_req_if.sv -----
// ----------------------------------------------------------------------------
// bfmtf_req_if
// Request channel: feed a byte or read a list position.
// ----------------------------------------------------------------------------
interface bfmtf_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] byte_value;
	logic [7:0] position;

	modport source (output valid, output opcode, output byte_value, output position,
		input ready);
	modport sink (input valid, input opcode, input byte_value, input position,
		output ready);
endinterface

// ----- design/bfmtf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bfmtf_rsp_if
// Response channel: one beat per list read.
// ----------------------------------------------------------------------------
interface bfmtf_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  entry_byte;
	logic [31:0] entry_count;
	logic        entry_valid;
	logic [8:0]  list_length;

	modport source (output valid, output entry_byte, output entry_count,
		output entry_valid, output list_length, input ready);
	modport sink (input valid, input entry_byte, input entry_count,
		input entry_valid, input list_length, output ready);
endinterface

// ----- design/byte_frequency_move_to_front_list.sv -----
// ----------------------------------------------------------------------------
// byte_frequency_move_to_front_list
// Ordered list of distinct bytes with saturating counts, move-to-front on hit.
// ----------------------------------------------------------------------------
// A feed searches the list from the front one entry per cycle through a
// memory with one read and one write port and a registered read. On a hit at
// position h the count is bumped and entries h-1 down to 0 move back one
// place, one per cycle, then the byte is written to the front. On a miss the
// byte is appended after a full scan, unless the list is full. A read issues
// the memory read, then loads the response register once it has drained. One
// request is in flight at a time; a feed returns no beat, a read returns one.
module byte_frequency_move_to_front_list
	import bfmtf_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	bfmtf_req_if.sink   req,
	bfmtf_rsp_if.source rsp
);

	bfmtf_cmd_t cmd;
	bfmtf_sts_t sts;

	bfmtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bfmtf_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_byte         (req.byte_value),
		.in_position     (req.position),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_byte        (rsp.entry_byte),
		.out_count       (rsp.entry_count),
		.out_entry_valid (rsp.entry_valid),
		.out_length      (rsp.list_length)
	);

endmodule

// ----- design/bfmtf_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfmtf_ctrl
// Sequencer for search, shift, head write, append and list read.
// ----------------------------------------------------------------------------
module bfmtf_ctrl
	import bfmtf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_opcode,
	output logic       in_ready,
	input  bfmtf_sts_t sts,
	output bfmtf_cmd_t cmd
);

	bfmtf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (in_opcode == OP_READ) ? ST_READ : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match) begin
					cmd.hit = 1'b1;
					state_d = ST_SHIFT;
				end else if (sts.miss) begin
					cmd.append = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				cmd.head = 1'b1;
				state_d = ST_IDLE;
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/bfmtf_datapath.sv -----
// ----------------------------------------------------------------------------
// bfmtf_datapath
// List memory, search and shift pointers, length and response register.
// ----------------------------------------------------------------------------
module bfmtf_datapath
	import bfmtf_pkg::*;
#(
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bfmtf_cmd_t             cmd,
	output bfmtf_sts_t             sts,
	input  logic [BYTE_W-1:0]      in_byte,
	input  logic [ADDR_W-1:0]      in_position,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [BYTE_W-1:0]      out_byte,
	output logic [OUT_COUNT_W-1:0] out_count,
	output logic                   out_entry_valid,
	output logic [LEN_W-1:0]       out_length
);

	localparam int ENTRY_W = BYTE_W + COUNT_WIDTH;

	logic [ENTRY_W-1:0]     mem_q [LIST_DEPTH];
	logic [ENTRY_W-1:0]     rd_data_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       addr_q;
	logic [ADDR_W-1:0]      rp_q;
	logic [ADDR_W-1:0]      dadr_q;
	logic                   dvld_q;
	logic [BYTE_W-1:0]      byte_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   out_vld_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic                   out_ev_q;
	logic [LEN_W-1:0]       out_len_q;

	logic                   eq;
	logic                   scan_issue;
	logic                   shift_issue;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [ENTRY_W-1:0]     wr_data;
	logic [COUNT_WIDTH-1:0] rd_count;
	logic [COUNT_WIDTH-1:0] inc_count;
	logic [OUT_COUNT_W-1:0] clamp_count;
	logic                   pos_in_list;
	logic                   can_append;

	assign rd_count  = rd_data_q[COUNT_WIDTH-1:0];
	assign inc_count = (&rd_count) ? rd_count : rd_count + COUNT_WIDTH'(1);
	assign eq        = (rd_data_q[ENTRY_W-1:COUNT_WIDTH] == byte_q);

	generate
		if (COUNT_WIDTH > OUT_COUNT_W) begin : g_clamp
			assign clamp_count = (|rd_count[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1
				: rd_count[OUT_COUNT_W-1:0];
		end else begin : g_ext
			assign clamp_count = OUT_COUNT_W'(rd_count);
		end
	endgenerate

	assign sts.match      = dvld_q & eq;
	assign sts.miss       = (addr_q >= len_q) & ~(dvld_q & eq);
	assign sts.shift_done = (rp_q == '0) & ~dvld_q;
	assign sts.out_busy   = out_vld_q & ~out_ready;

	assign scan_issue  = cmd.scan & ~(dvld_q & eq) & (addr_q < len_q);
	assign shift_issue = cmd.shift & (rp_q != '0);
	assign rd_en       = scan_issue | shift_issue | cmd.rd_issue;
	assign pos_in_list = ({1'b0, pos_q} < len_q);
	assign can_append  = ~len_q[LEN_W-1];

	always_comb begin
		priority if (cmd.scan) begin
			rd_addr = addr_q[ADDR_W-1:0];
		end else if (cmd.shift) begin
			rd_addr = rp_q - ADDR_W'(1);
		end else begin
			rd_addr = pos_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = dadr_q + ADDR_W'(1);
		wr_data = rd_data_q;
		priority if (cmd.shift && dvld_q) begin
			wr_en = 1'b1;
		end else if (cmd.head) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = {byte_q, cnt_q};
		end else if (cmd.append && can_append) begin
			wr_en   = 1'b1;
			wr_addr = len_q[ADDR_W-1:0];
			wr_data = {byte_q, COUNT_WIDTH'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		dadr_q <= rd_addr;
		if (cmd.capture) begin
			byte_q <= in_byte;
			pos_q  <= in_position;
		end
		if (cmd.hit) begin
			cnt_q <= inc_count;
			rp_q  <= dadr_q;
		end else if (shift_issue) begin
			rp_q <= rp_q - ADDR_W'(1);
		end
		if (cmd.load) begin
			out_ev_q    <= pos_in_list;
			out_byte_q  <= pos_in_list ? rd_data_q[ENTRY_W-1:COUNT_WIDTH] : '0;
			out_count_q <= pos_in_list ? clamp_count : '0;
			out_len_q   <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			addr_q    <= '0;
			dvld_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			dvld_q <= scan_issue | shift_issue;
			if (cmd.capture) begin
				addr_q <= '0;
			end else if (scan_issue) begin
				addr_q <= addr_q + LEN_W'(1);
			end
			if (cmd.append && can_append) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (cmd.load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_vld_q;
	assign out_byte        = out_byte_q;
	assign out_count       = out_count_q;
	assign out_entry_valid = out_ev_q;
	assign out_length      = out_len_q;

endmodule

// ----- design/bfmtf_checker.sv -----
// ----------------------------------------------------------------------------
// bfmtf_checker
// Port-level checks on the response channel of the move-to-front list.
// ----------------------------------------------------------------------------
module bfmtf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  rsp_entry_byte,
	input logic [31:0] rsp_entry_count,
	input logic        rsp_entry_valid,
	input logic [8:0]  rsp_list_length
);

	logic       seen_q;
	logic [8:0] last_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_len_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			seen_q     <= 1'b1;
			last_len_q <= rsp_list_length;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_byte)
			&& $stable(rsp_entry_count) && $stable(rsp_list_length))
		else $error("response beat changed while stalled");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_list_length <= 9'd256
			&& (!rsp_entry_valid || rsp_list_length != 9'd0))
		else $error("list length out of range");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_entry_valid |-> rsp_entry_byte == 8'd0
			&& rsp_entry_count == 32'd0)
		else $error("invalid entry carries nonzero payload");

	a_len_grow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && seen_q |-> rsp_list_length >= last_len_q)
		else $error("list length shrank");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_entry_valid |-> rsp_entry_count != 32'd0)
		else $error("listed entry with zero count");

endmodule

bind byte_frequency_move_to_front_list bfmtf_checker u_bfmtf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_entry_byte  (rsp.entry_byte),
	.rsp_entry_count (rsp.entry_count),
	.rsp_entry_valid (rsp.entry_valid),
	.rsp_list_length (rsp.list_length)
);

// ----- tb/tb_byte_frequency_move_to_front_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_frequency_move_to_front_list
// Self-checking bench for the byte frequency move-to-front list. A short
// table of feeds and reads runs first. Random traffic then fills the list to
// all 256 byte values and hits entries at random depths. Every read beat is
// checked against the table's expected beat or an in-bench copy of the list,
// and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_byte_frequency_move_to_front_list;
	import bfmtf_pkg::*;

	localparam int COUNT_W       = DEF_COUNT_WIDTH;
	localparam int RANDOM_ITEMS  = 426;
	localparam int DIRECTED_ROWS = 24;
	localparam int DRAIN_CYCLES  = 600;
	localparam int STALL_LIMIT   = 5000;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [7:0]  entry_byte;
		logic [31:0] entry_count;
		logic        entry_valid;
		logic [8:0]  list_length;
	} list_entry_t;

	typedef struct packed {
		bfmtf_op_t   op;
		logic [7:0]  byte_value;
		logic [7:0]  position;
		logic        typed;
		list_entry_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bfmtf_req_if req ();
	bfmtf_rsp_if rsp ();

	byte_frequency_move_to_front_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	logic [7:0]         mtf_byte  [LIST_DEPTH];
	logic [COUNT_W-1:0] mtf_count [LIST_DEPTH];
	int                 mtf_len = 0;

	list_entry_t pending_reads [$];
	int          mismatches  = 0;
	int          idle_cycles = 0;
	bit          req_burst   = 1'b0;
	bit          rsp_burst   = 1'b0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_READ, 8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
		'{OP_READ, 8'hFF, 8'hFF, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd0}},
		'{OP_FEED, 8'h00, 8'hFF, 1'b0, '0},
		'{OP_FEED, 8'hFF, 8'h00, 1'b0, '0},
		'{OP_READ, 8'hC3, 8'h00, 1'b1, '{8'h00, 32'd1, 1'b1, 9'd2}},
		'{OP_READ, 8'h3C, 8'h01, 1'b1, '{8'hFF, 32'd1, 1'b1, 9'd2}},
		'{OP_FEED, 8'hFF, 8'h80, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h00, 1'b1, '{8'hFF, 32'd2, 1'b1, 9'd2}},
		'{OP_READ, 8'h00, 8'h01, 1'b1, '{8'h00, 32'd1, 1'b1, 9'd2}},
		'{OP_READ, 8'h00, 8'h02, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd2}},
		'{OP_FEED, 8'hFF, 8'h7F, 1'b0, '0},
		'{OP_FEED, 8'hA5, 8'h00, 1'b0, '0},
		'{OP_FEED, 8'h5A, 8'h00, 1'b0, '0},
		'{OP_FEED, 8'h5A, 8'hFF, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h00, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h03, 1'b0, '0},
		'{OP_READ, 8'hFF, 8'hFF, 1'b1, '{8'h00, 32'd0, 1'b0, 9'd4}},
		'{OP_FEED, 8'h80, 8'h00, 1'b0, '0},
		'{OP_FEED, 8'h01, 8'h00, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h05, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h04, 1'b0, '0},
		'{OP_FEED, 8'h00, 8'h00, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h00, 1'b0, '0},
		'{OP_READ, 8'h00, 8'h02, 1'b0, '0}
	};

	function automatic void mtf_feed(input logic [7:0] b);
		int                 hit;
		logic [COUNT_W-1:0] c;
		hit = mtf_len;
		for (int p = 0; p < mtf_len; p++) begin
			if (mtf_byte[p] == b) begin
				hit = p;
				break;
			end
		end
		if (hit < mtf_len) begin
			c = mtf_count[hit];
			if (c != '1)
				c = c + 1'b1;
			for (int p = hit; p > 0; p--) begin
				mtf_byte[p]  = mtf_byte[p-1];
				mtf_count[p] = mtf_count[p-1];
			end
			mtf_byte[0]  = b;
			mtf_count[0] = c;
		end else if (mtf_len < LIST_DEPTH) begin
			mtf_byte[mtf_len]  = b;
			mtf_count[mtf_len] = COUNT_W'(1);
			mtf_len++;
		end
	endfunction

	function automatic list_entry_t mtf_lookup(input logic [7:0] pos);
		list_entry_t e;
		logic [63:0] wide;
		e = '0;
		e.list_length = 9'(mtf_len);
		if (int'(pos) < mtf_len) begin
			wide          = 64'(mtf_count[pos]);
			e.entry_byte  = mtf_byte[pos];
			e.entry_count = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
			e.entry_valid = 1'b1;
		end
		return e;
	endfunction

	task automatic send_item(input stim_row_t row);
		int gap;
		if ($urandom_range(0, 19) == 0)
			req_burst = !req_burst;
		gap = req_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.opcode     <= row.op;
		req.byte_value <= row.byte_value;
		req.position   <= row.position;
		do @(posedge clk); while (!req.ready);
		if (row.op == OP_READ)
			pending_reads.insert(pending_reads.size(),
				row.typed ? row.want : mtf_lookup(row.position));
		else
			mtf_feed(row.byte_value);
	endtask

	initial begin
		stim_row_t row;
		int        fresh [LIST_DEPTH];
		int        fresh_next;
		int        n;
		int        j;
		int        t;
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.opcode     <= OP_FEED;
		req.byte_value <= 8'h00;
		req.position   <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		for (int i = 0; i < LIST_DEPTH; i++)
			fresh[i] = i;
		for (int i = LIST_DEPTH - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = fresh[i];
			fresh[i] = fresh[j];
			fresh[j] = t;
		end

		// grow the list with unseen bytes, revisit entries at any depth, read anywhere
		fresh_next = 0;
		n          = 0;
		while (n < RANDOM_ITEMS || mtf_len < LIST_DEPTH) begin
			row            = '0;
			row.byte_value = 8'($urandom_range(0, 255));
			row.position   = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 75) begin
				row.op = OP_FEED;
				if (fresh_next < LIST_DEPTH && $urandom_range(0, 7) != 0) begin
					row.byte_value = 8'(fresh[fresh_next]);
					fresh_next++;
				end else if (mtf_len > 0 && $urandom_range(0, 1) == 1) begin
					row.byte_value = mtf_byte[$urandom_range(0, mtf_len - 1)];
				end
			end else begin
				row.op = OP_READ;
				if (mtf_len > 0 && $urandom_range(0, 1) == 1)
					row.position = 8'($urandom_range(0, mtf_len - 1));
			end
			send_item(row);
			n++;
		end
		req.valid <= 1'b0;

		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reads.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		int          stall;
		list_entry_t got;
		list_entry_t want;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0)
				rsp_burst = !rsp_burst;
			stall = rsp_burst ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			got = '{rsp.entry_byte, rsp.entry_count, rsp.entry_valid, rsp.list_length};
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected read beat: byte %02h count %0d valid %0b length %0d",
						got.entry_byte, got.entry_count, got.entry_valid, got.list_length);
			end else begin
				want = pending_reads.pop_front();
				if (got.entry_byte !== want.entry_byte || got.entry_count !== want.entry_count
					|| got.entry_valid !== want.entry_valid
					|| got.list_length !== want.list_length) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"read beat mismatch: expected byte %02h count %0d valid %0b",
							" length %0d, got byte %02h count %0d valid %0b length %0d"},
							want.entry_byte, want.entry_count, want.entry_valid,
							want.list_length, got.entry_byte, got.entry_count,
							got.entry_valid, got.list_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("no beat accepted for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
